// ----- src/signed_divide_64by32_saturating_core_assert.svh -----
// Assertion macros shared by the signed divide core RTL.
// No dependencies; relies on clk and arst_n being in scope at the point of use.
`ifndef SIGNED_DIVIDE_64BY32_SATURATING_CORE_ASSERT_SVH
`define SIGNED_DIVIDE_64BY32_SATURATING_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Implication checked on every clock edge outside reset
`define SDIV_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Invariant checked on every clock edge outside reset
`define SDIV_ASSERT_NOW(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);
`else
`define SDIV_ASSERT_IMP(lbl, ante, cons, msg)
`define SDIV_ASSERT_NOW(lbl, cond, msg)
`endif
`endif

// ----- src/sdiv_pkg.sv -----
// Types and constants for the signed 64-by-32 saturating divide pipeline.
// No dependencies.
package sdiv_pkg;

	localparam int unsigned WORD_W     = 32;
	localparam int unsigned DEST_W     = 5;
	localparam int unsigned STEP_COUNT = WORD_W;
	// two operand stages, one stage per quotient bit, one result stage
	localparam int unsigned PIPE_DEPTH = STEP_COUNT + 3;

	localparam logic [WORD_W-1:0] POS_LIMIT = 32'h7fff_ffff;
	localparam logic [WORD_W-1:0] NEG_LIMIT = 32'h8000_0000;

	localparam int unsigned INSTR_IMM_BIT = 13;
	localparam int unsigned INSTR_RD_LSB  = 25;
	localparam int unsigned SIMM_W        = 13;

	// One instruction in flight through the divide stages
	typedef struct packed {
		logic [DEST_W-1:0] dest;  // destination register
		logic              dz;    // divisor was zero
		logic              neg;   // quotient sign
		logic              big;   // quotient magnitude at least 2^32
		logic [WORD_W-1:0] den;   // divisor magnitude
		logic [WORD_W-1:0] rem;   // partial remainder
		logic [WORD_W-1:0] lo;    // dividend bits left, quotient bits shifted in
	} sdiv_tok_t;

endpackage

// ----- src/sdiv_prep.sv -----
// Operand stages: divisor select, magnitudes, quotient range check.
// Depends on sdiv_pkg.
module sdiv_prep (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_vld,
	input  logic [sdiv_pkg::WORD_W-1:0]   instruction,
	input  logic [sdiv_pkg::WORD_W-1:0]   y_value,
	input  logic [sdiv_pkg::WORD_W-1:0]   src1_value,
	input  logic signed [sdiv_pkg::WORD_W-1:0] src2_value,
	output logic                          out_vld,
	output sdiv_pkg::sdiv_tok_t           out_tok
);
	import sdiv_pkg::*;

	logic [WORD_W-1:0]   divisor;
	logic [2*WORD_W-1:0] dividend;

	logic                vld_s1;
	logic [DEST_W-1:0]   dest_s1;
	logic                dz_s1;
	logic                neg_s1;
	logic [2*WORD_W-1:0] num_s1;
	logic [WORD_W-1:0]   den_s1;

	logic                vld_s2;
	sdiv_tok_t           tok_s2;

	// Select and sign-extend the divisor
	always_comb begin
		if (instruction[INSTR_IMM_BIT]) begin
			divisor = {{(WORD_W-SIMM_W){instruction[SIMM_W-1]}}, instruction[SIMM_W-1:0]};
		end else begin
			divisor = src2_value;
		end
		dividend = {y_value, src1_value};
	end

	// Stage 1: take magnitudes of both operands
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		dest_s1 <= instruction[INSTR_RD_LSB +: DEST_W];
		dz_s1   <= (divisor == '0);
		neg_s1  <= y_value[WORD_W-1] ^ divisor[WORD_W-1];
		num_s1  <= dividend[2*WORD_W-1] ? (~dividend + 64'd1) : dividend;
		den_s1  <= divisor[WORD_W-1] ? (~divisor + 32'd1) : divisor;
	end

	// Stage 2: flag a quotient of 2^32 or more, load the remainder
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		tok_s2.dest <= dest_s1;
		tok_s2.dz   <= dz_s1;
		tok_s2.neg  <= neg_s1;
		tok_s2.big  <= (num_s1[2*WORD_W-1:WORD_W] >= den_s1);
		tok_s2.den  <= den_s1;
		tok_s2.rem  <= num_s1[2*WORD_W-1:WORD_W];
		tok_s2.lo   <= num_s1[WORD_W-1:0];
	end

	assign out_vld = vld_s2;
	assign out_tok = tok_s2;

endmodule

// ----- src/sdiv_step.sv -----
// One restoring-division stage: develops one quotient bit per beat.
// Depends on sdiv_pkg.
module sdiv_step (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_vld,
	input  sdiv_pkg::sdiv_tok_t in_tok,
	output logic                out_vld,
	output sdiv_pkg::sdiv_tok_t out_tok
);
	import sdiv_pkg::*;

	logic [WORD_W:0]   rem_ext;
	logic [WORD_W+1:0] diff;
	logic              ge;
	sdiv_tok_t         nxt;

	// the register of this one stage; its place in the chain is set by the top level
	logic              vld_sk;
	sdiv_tok_t         tok_sk;

	// Shift in the next dividend bit, trial-subtract the divisor
	always_comb begin
		rem_ext = {in_tok.rem, in_tok.lo[WORD_W-1]};
		diff    = {1'b0, rem_ext} - {2'b00, in_tok.den};
		ge      = ~diff[WORD_W+1];
		nxt     = in_tok;
		nxt.rem = ge ? diff[WORD_W-1:0] : rem_ext[WORD_W-1:0];
		nxt.lo  = {in_tok.lo[WORD_W-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sk <= 1'b0;
		end else begin
			vld_sk <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		tok_sk <= nxt;
	end

	assign out_vld = vld_sk;
	assign out_tok = tok_sk;

endmodule

// ----- src/sdiv_post.sv -----
// Result stage: sign restore, saturation and flags.
// Depends on sdiv_pkg.
module sdiv_post (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_vld,
	input  sdiv_pkg::sdiv_tok_t         in_tok,
	output logic                        done,
	output logic [sdiv_pkg::WORD_W-1:0] quotient,
	output logic [sdiv_pkg::DEST_W-1:0] dest_reg,
	output logic                        zero_trap,
	output logic                        overflowed
);
	import sdiv_pkg::*;

	logic [WORD_W-1:0] q_mag;
	logic [WORD_W-1:0] q_nxt;
	logic              ovf_nxt;

	logic              vld_s35;
	logic [WORD_W-1:0] quot_s35;
	logic [DEST_W-1:0] dest_s35;
	logic              dz_s35;
	logic              ovf_s35;

	// Restore the sign, clamp out-of-range quotients, force zero for a zero divisor
	always_comb begin
		q_mag   = in_tok.lo;
		q_nxt   = q_mag;
		ovf_nxt = 1'b0;
		priority if (in_tok.dz) begin
			q_nxt   = '0;
			ovf_nxt = 1'b0;
		end else if (in_tok.big) begin
			q_nxt   = in_tok.neg ? NEG_LIMIT : POS_LIMIT;
			ovf_nxt = 1'b1;
		end else if (!in_tok.neg) begin
			ovf_nxt = q_mag[WORD_W-1];
			q_nxt   = q_mag[WORD_W-1] ? POS_LIMIT : q_mag;
		end else begin
			ovf_nxt = q_mag[WORD_W-1] & (|q_mag[WORD_W-2:0]);
			q_nxt   = ovf_nxt ? NEG_LIMIT : (~q_mag + 32'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s35 <= 1'b0;
		end else begin
			vld_s35 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		quot_s35 <= q_nxt;
		dest_s35 <= in_tok.dest;
		dz_s35   <= in_tok.dz;
		ovf_s35  <= ovf_nxt;
	end

	assign done       = vld_s35;
	assign quotient   = quot_s35;
	assign dest_reg   = dest_s35;
	assign zero_trap  = dz_s35;
	assign overflowed = ovf_s35;

endmodule

// ----- src/signed_divide_64by32_saturating_core.sv -----
// Signed 64-by-32 saturating divide: one instruction accepted every cycle, busy is never
// raised. Each start beat reaches done through these stages in order: two operand stages,
// 32 restoring-division stages (one quotient bit each, a 33-bit compare-subtract), and one
// saturation stage. The receiver cannot stall; every result is shown for one cycle.
// Depends on sdiv_pkg, sdiv_prep, sdiv_step, sdiv_post and the assertion macro header.
`include "signed_divide_64by32_saturating_core_assert.svh"

module signed_divide_64by32_saturating_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [sdiv_pkg::WORD_W-1:0]       instruction,
	input  logic [sdiv_pkg::WORD_W-1:0]       y_value,
	input  logic [sdiv_pkg::WORD_W-1:0]       src1_value,
	input  logic signed [sdiv_pkg::WORD_W-1:0] src2_value,
	output logic                              done,
	output logic [sdiv_pkg::WORD_W-1:0]       quotient,
	output logic [sdiv_pkg::DEST_W-1:0]       dest_reg,
	output logic                              zero_trap,
	output logic                              overflowed
);
	import sdiv_pkg::*;

	logic      vld_chain [STEP_COUNT+1];
	sdiv_tok_t tok_chain [STEP_COUNT+1];

	// Never hold off a beat
	assign busy = 1'b0;

	sdiv_prep u_prep (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_vld      (start),
		.instruction (instruction),
		.y_value     (y_value),
		.src1_value  (src1_value),
		.src2_value  (src2_value),
		.out_vld     (vld_chain[0]),
		.out_tok     (tok_chain[0])
	);

	// One stage per quotient bit
	for (genvar g = 0; g < STEP_COUNT; g++) begin : g_step
		sdiv_step u_step (
			.clk     (clk),
			.arst_n  (arst_n),
			.in_vld  (vld_chain[g]),
			.in_tok  (tok_chain[g]),
			.out_vld (vld_chain[g+1]),
			.out_tok (tok_chain[g+1])
		);
	end

	sdiv_post u_post (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_vld     (vld_chain[STEP_COUNT]),
		.in_tok     (tok_chain[STEP_COUNT]),
		.done       (done),
		.quotient   (quotient),
		.dest_reg   (dest_reg),
		.zero_trap  (zero_trap),
		.overflowed (overflowed)
	);

	// A result comes only from a start beat that went through the whole pipeline
	`SDIV_ASSERT_IMP(a_done_latency, done, $past(start, PIPE_DEPTH), "done without matching start")
	// Zero divisor leaves quotient and clamp flag clear
	`SDIV_ASSERT_IMP(a_dz_clean, done && zero_trap, quotient == '0 && !overflowed, "bad dz result")
	// A clamp always lands on one of the two limits
	`SDIV_ASSERT_IMP(a_ovf_limit, done && overflowed,
		quotient == POS_LIMIT || quotient == NEG_LIMIT, "clamp off the limits")
	// Never stall the input
	`SDIV_ASSERT_NOW(a_never_busy, !busy, "busy raised")

endmodule

// ----- verif/sdiv_checker.sv -----
`timescale 1ns / 100ps
// Result checker for the signed 64-by-32 saturating divide core: predicts each accepted beat
// and compares every done strobe against the oldest prediction. Depends on sdiv_pkg.
module sdiv_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic                              busy,
	input  logic [sdiv_pkg::WORD_W-1:0]       instruction,
	input  logic [sdiv_pkg::WORD_W-1:0]       y_value,
	input  logic [sdiv_pkg::WORD_W-1:0]       src1_value,
	input  logic [sdiv_pkg::WORD_W-1:0]       src2_value,
	input  logic                              done,
	input  logic [sdiv_pkg::WORD_W-1:0]       quotient,
	input  logic [sdiv_pkg::DEST_W-1:0]       dest_reg,
	input  logic                              zero_trap,
	input  logic                              overflowed,
	output int unsigned                       fail_count,
	output int unsigned                       pending
);
	import sdiv_pkg::*;

	typedef struct packed {
		logic [WORD_W-1:0] quo;
		logic [DEST_W-1:0] dest;
		logic              dz;
		logic              ovf;
	} div_result_t;

	div_result_t quotient_q[$];
	int unsigned mismatches = 0;

	assign fail_count = mismatches;

	// Saturating signed divide of {hi, lo} by the selected divisor
	function automatic div_result_t divide_saturate(input logic [WORD_W-1:0] instr,
			input logic [WORD_W-1:0] hi, input logic [WORD_W-1:0] lo,
			input logic [WORD_W-1:0] rs2);
		div_result_t r;
		logic [63:0] dividend;
		logic [63:0] divisor;
		logic [63:0] num_mag;
		logic [63:0] den_mag;
		logic [63:0] q_mag;
		logic [63:0] q_neg;
		logic        neg;
		r.quo  = '0;
		r.dest = instr[INSTR_RD_LSB +: DEST_W];
		r.dz   = 1'b0;
		r.ovf  = 1'b0;
		dividend = {hi, lo};
		if (instr[INSTR_IMM_BIT]) begin
			divisor = {{(64-SIMM_W){instr[SIMM_W-1]}}, instr[SIMM_W-1:0]};
		end else begin
			divisor = {{32{rs2[WORD_W-1]}}, rs2};
		end
		if (divisor == 64'd0) begin
			r.dz = 1'b1;
		end else begin
			num_mag = dividend[63] ? (64'd0 - dividend) : dividend;
			den_mag = divisor[63] ? (64'd0 - divisor) : divisor;
			q_mag = num_mag / den_mag;
			neg = dividend[63] ^ divisor[63];
			// clamp outside the signed 32-bit range
			if (!neg) begin
				if (q_mag > {32'd0, POS_LIMIT}) begin
					r.quo = POS_LIMIT;
					r.ovf = 1'b1;
				end else begin
					r.quo = q_mag[WORD_W-1:0];
				end
			end else begin
				if (q_mag > {32'd0, NEG_LIMIT}) begin
					r.quo = NEG_LIMIT;
					r.ovf = 1'b1;
				end else begin
					q_neg = 64'd0 - q_mag;
					r.quo = q_neg[WORD_W-1:0];
				end
			end
		end
		return r;
	endfunction

	// Print one line per mismatch and count it
	task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
			input logic [WORD_W-1:0] want);
		$display("%0t sdiv_checker: %s got %h expected %h", $time, what, got, want);
		mismatches++;
	endtask

	// Push a prediction per accepted beat, pop and compare per done strobe
	always @(posedge clk or negedge arst_n) begin
		div_result_t want;
		if (!arst_n) begin
			quotient_q.delete();
			pending <= 0;
		end else begin
			if (done) begin
				if (quotient_q.size() == 0) begin
					report_mismatch("unexpected result, quotient", quotient, '0);
				end else begin
					want = quotient_q.pop_front();
					if (quotient !== want.quo)
						report_mismatch("quotient", quotient, want.quo);
					if (dest_reg !== want.dest)
						report_mismatch("dest_reg", {27'd0, dest_reg}, {27'd0, want.dest});
					if (zero_trap !== want.dz)
						report_mismatch("zero_trap", {31'd0, zero_trap}, {31'd0, want.dz});
					if (overflowed !== want.ovf)
						report_mismatch("overflowed", {31'd0, overflowed}, {31'd0, want.ovf});
				end
			end
			if (start && !busy) begin
				quotient_q.push_back(divide_saturate(instruction, y_value, src1_value,
					src2_value));
			end
			pending <= quotient_q.size();
		end
	end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// Stimulus top for the signed 64-by-32 saturating divide core: directed corner beats, then
// random beats with random gaps. Depends on sdiv_pkg, the core and sdiv_checker.
module tb_top;
	import sdiv_pkg::*;

	localparam int unsigned RANDOM_BEATS = 1650;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [WORD_W-1:0] instruction;
	logic [WORD_W-1:0] y_value;
	logic [WORD_W-1:0] src1_value;
	logic [WORD_W-1:0] src2_value;
	logic              done;
	logic [WORD_W-1:0] quotient;
	logic [DEST_W-1:0] dest_reg;
	logic              zero_trap;
	logic              overflowed;
	logic              accept_q;
	int unsigned       fail_count;
	int unsigned       pending;

	signed_divide_64by32_saturating_core u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.instruction (instruction),
		.y_value     (y_value),
		.src1_value  (src1_value),
		.src2_value  (src2_value),
		.done        (done),
		.quotient    (quotient),
		.dest_reg    (dest_reg),
		.zero_trap   (zero_trap),
		.overflowed  (overflowed)
	);

	sdiv_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.instruction (instruction),
		.y_value     (y_value),
		.src1_value  (src1_value),
		.src2_value  (src2_value),
		.done        (done),
		.quotient    (quotient),
		.dest_reg    (dest_reg),
		.zero_trap   (zero_trap),
		.overflowed  (overflowed),
		.fail_count  (fail_count),
		.pending     (pending)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Remember whether the last rising edge took a beat
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accept_q <= 1'b0;
		end else begin
			accept_q <= start && !busy;
		end
	end

	// Build an instruction word with random unused bits
	function automatic logic [WORD_W-1:0] make_instr(input logic [DEST_W-1:0] rd,
			input logic imm_sel, input logic [SIMM_W-1:0] simm);
		logic [WORD_W-1:0] w;
		w = $urandom;
		w[INSTR_RD_LSB +: DEST_W] = rd;
		w[INSTR_IMM_BIT] = imm_sel;
		w[SIMM_W-1:0] = simm;
		return w;
	endfunction

	// Drive one beat at a falling edge and hold it until accepted
	task automatic send_div(input logic [WORD_W-1:0] instr, input logic [WORD_W-1:0] hi,
			input logic [WORD_W-1:0] lo, input logic [WORD_W-1:0] dvs);
		start <= 1'b1;
		instruction <= instr;
		y_value <= hi;
		src1_value <= lo;
		src2_value <= dvs;
		do @(negedge clk); while (!accept_q);
	endtask

	// Stop the run if it hangs
	initial begin
		#(10_000_000);
		$display("tb_top: FAIL");
		$finish;
	end

	initial begin
		longint      q_tgt;
		longint      dvs;
		longint      off;
		longint      dvd;
		int unsigned d_mag;
		int unsigned span;
		int unsigned kind;
		int unsigned gap;
		logic [WORD_W-1:0] hi;
		logic [WORD_W-1:0] lo;
		logic [DEST_W-1:0] rd;
		logic [63:0] dvd_bits;

		arst_n = 1'b0;
		start = 1'b0;
		instruction = '0;
		y_value = '0;
		src1_value = '0;
		src2_value = '0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed corners, back to back
		send_div(make_instr(5'd1, 1'b0, 13'h0123), 32'h0, 32'd100, 32'd7);
		send_div(make_instr(5'd2, 1'b0, 13'h0000), 32'hffff_ffff, 32'hffff_fff9, 32'd2);
		send_div(make_instr(5'd3, 1'b0, 13'h1fff), 32'h0, 32'd7, 32'hffff_fffe);
		send_div(make_instr(5'd4, 1'b0, 13'h0abc), 32'hffff_ffff, 32'hffff_fff9,
			32'hffff_fffe);
		// zero divisor from the register and from the immediate
		send_div(make_instr(5'd31, 1'b0, 13'h0000), 32'h1234_5678, 32'h9abc_def0, 32'h0);
		send_div(make_instr(5'd6, 1'b1, 13'h0000), 32'h0, 32'd77, 32'd5);
		send_div(make_instr(5'd7, 1'b0, 13'h1555), 32'h0, 32'd77, 32'h0);
		// most negative dividend over minus one
		send_div(make_instr(5'd8, 1'b0, 13'h0000), 32'h8000_0000, 32'h0, 32'hffff_ffff);
		send_div(make_instr(5'd9, 1'b1, 13'h1fff), 32'h8000_0000, 32'h0, 32'h0);
		// quotient exactly -2^31 stays unclamped
		send_div(make_instr(5'd10, 1'b0, 13'h0000), 32'hffff_ffff, 32'h8000_0000, 32'd1);
		send_div(make_instr(5'd11, 1'b0, 13'h0000), 32'h0, 32'h8000_0000, 32'hffff_ffff);
		// just past each limit
		send_div(make_instr(5'd12, 1'b0, 13'h0000), 32'h0, 32'h8000_0000, 32'd1);
		send_div(make_instr(5'd13, 1'b0, 13'h0000), 32'hffff_ffff, 32'h7fff_ffff, 32'd1);
		send_div(make_instr(5'd14, 1'b0, 13'h0000), 32'h7fff_ffff, 32'hffff_ffff,
			32'h7fff_ffff);
		send_div(make_instr(5'd15, 1'b0, 13'h0000), 32'h8000_0000, 32'h0, 32'h8000_0000);
		// immediate extremes, all-ones and all-zero instruction words, divide by minus one
		send_div(make_instr(5'd16, 1'b1, 13'h0fff), 32'h0, 32'hffff_ffff, 32'h0);
		send_div(make_instr(5'd17, 1'b1, 13'h1000), 32'h0, 32'd12345678, 32'hffff_ffff);
		send_div(32'hffff_ffff, 32'h0, 32'd5, 32'hffff_ffff);
		send_div(32'h0, 32'h0, 32'd9, 32'd3);
		send_div(make_instr(5'd20, 1'b0, 13'h0000), 32'hffff_ffff, 32'hffff_ffff,
			32'hffff_ffff);
		send_div(make_instr(5'd21, 1'b0, 13'h0000), 32'h0, 32'h0, 32'hffff_ffff);

		// Random beats
		for (int n = 0; n < RANDOM_BEATS; n++) begin
			kind = $urandom_range(0, 99);
			rd = DEST_W'($urandom);
			if (kind < 15) begin
				send_div($urandom, $urandom, $urandom, $urandom);
			end else if (kind < 40) begin
				// 32-bit dividend, mostly in range
				lo = $urandom;
				hi = {32{lo[WORD_W-1]}};
				if ($urandom_range(0, 1)) begin
					send_div(make_instr(rd, 1'b1, SIMM_W'($urandom)), hi, lo, $urandom);
				end else begin
					send_div(make_instr(rd, 1'b0, SIMM_W'($urandom)), hi, lo, $urandom);
				end
			end else if (kind < 60) begin
				// quotient around a saturation limit
				case ($urandom_range(0, 4))
					0: q_tgt = 64'sd2147483647;
					1: q_tgt = 64'sd2147483648;
					2: q_tgt = -64'sd2147483648;
					3: q_tgt = -64'sd2147483649;
					default: q_tgt = -64'sd2147483647;
				endcase
				if ($urandom_range(0, 1)) begin
					d_mag = $urandom_range(1, 4095);
				end else begin
					d_mag = $urandom_range(1, 32'h3fff_ffff);
				end
				dvs = $urandom_range(0, 1) ? -longint'(d_mag) : longint'(d_mag);
				span = 2 * d_mag - 1;
				off = longint'($urandom_range(0, span)) - longint'(d_mag);
				dvd = q_tgt * dvs + off;
				dvd_bits = dvd;
				if (d_mag < 4096 && $urandom_range(0, 1)) begin
					send_div(make_instr(rd, 1'b1, dvs[SIMM_W-1:0]), dvd_bits[63:32],
						dvd_bits[31:0], $urandom);
				end else begin
					send_div(make_instr(rd, 1'b0, SIMM_W'($urandom)), dvd_bits[63:32],
						dvd_bits[31:0], dvs[31:0]);
				end
			end else if (kind < 80) begin
				// immediate divisor with a small high word of either sign
				hi = $urandom_range(0, 15) ^ {32{1'($urandom_range(0, 1))}};
				send_div(make_instr(rd, 1'b1, SIMM_W'($urandom)), hi, $urandom, $urandom);
			end else if (kind < 88) begin
				// zero divisor
				if ($urandom_range(0, 1)) begin
					send_div(make_instr(rd, 1'b1, 13'h0000), $urandom, $urandom, $urandom);
				end else begin
					send_div(make_instr(rd, 1'b0, SIMM_W'($urandom)), $urandom, $urandom,
						32'h0);
				end
			end else begin
				// divide by plus or minus one or two
				case ($urandom_range(0, 3))
					0: dvs = 1;
					1: dvs = -1;
					2: dvs = 2;
					default: dvs = -2;
				endcase
				send_div(make_instr(rd, 1'b0, SIMM_W'($urandom)), $urandom, $urandom,
					dvs[31:0]);
			end

			// Idle between beats, except in some bursts
			gap = 0;
			if ((n / 100) % 3 != 0) begin
				kind = $urandom_range(0, 99);
				if (kind >= 97) gap = $urandom_range(20, 60);
				else if (kind >= 90) gap = $urandom_range(4, 10);
				else if (kind >= 60) gap = $urandom_range(1, 3);
			end
			if (gap != 0) begin
				start <= 1'b0;
				instruction <= $urandom;
				y_value <= $urandom;
				src1_value <= $urandom;
				src2_value <= $urandom;
				repeat (gap) @(negedge clk);
			end
		end

		// Drain and watch for stray results
		start <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (PIPE_DEPTH + 10) @(negedge clk);
		if (fail_count == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+src
src/sdiv_pkg.sv
src/sdiv_prep.sv
src/sdiv_step.sv
src/sdiv_post.sv
src/signed_divide_64by32_saturating_core.sv
verif/sdiv_checker.sv
verif/tb_top.sv
